/* src/vlmr_pkg.sv */
package vlmr_pkg;

  // Ring geometry
  localparam int RING_BYTES  = 4096;
  localparam int AW          = 12;
  localparam int LW          = 13;
  localparam int MAX_PAYLOAD = 254;
  localparam int MIN_ACTIVE  = 16;
  localparam logic [7:0] WRAP_MARK = 8'hFF;

  // Iterative remainder: quotient of an address by active_length stays below 2**MOD_STEPS
  localparam int MOD_STEPS = 9;
  localparam int SHW       = 4;

  // Operation kinds
  localparam logic [2:0] KIND_ALLOC  = 3'd0;
  localparam logic [2:0] KIND_APPEND = 3'd1;
  localparam logic [2:0] KIND_POST   = 3'd2;
  localparam logic [2:0] KIND_OPEN   = 3'd3;
  localparam logic [2:0] KIND_READ   = 3'd4;
  localparam logic [2:0] KIND_FREE   = 3'd5;

  // Result status codes
  localparam logic [2:0] STS_OK       = 3'd0;
  localparam logic [2:0] STS_TOO_LONG = 3'd1;
  localparam logic [2:0] STS_OVERFLOW = 3'd2;
  localparam logic [2:0] STS_EMPTY    = 3'd3;
  localparam logic [2:0] STS_OUTSIDE  = 3'd4;

  // Ring read address selection
  localparam logic [1:0] RD_RO   = 2'd0;
  localparam logic [1:0] RD_ZERO = 2'd1;
  localparam logic [1:0] RD_REM  = 2'd2;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic            load;
    logic            capture_b;
    logic            mod_load;
    logic            mod_step;
    logic [SHW-1:0]  mod_shift;
    logic            rd_en;
    logic [1:0]      rd_sel;
    logic            commit;
  } vlmr_cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    logic [2:0] kind;
  } vlmr_stat_t;

endpackage

/* src/vlmr_ctrl.sv */
module vlmr_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  logic                out_tready,
  input  vlmr_pkg::vlmr_stat_t stat,
  output vlmr_pkg::vlmr_cmd_t  cmd
);
  import vlmr_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_LOOK = 3'd1;
  localparam logic [2:0] S_MOD  = 3'd2;
  localparam logic [2:0] S_RDM  = 3'd3;
  localparam logic [2:0] S_FIN  = 3'd4;

  logic [2:0]     state_r, state_nxt;
  logic [SHW-1:0] cnt_r, cnt_nxt;
  logic           out_valid_r, out_valid_nxt;

  // Sequencing of one operation
  always_comb begin
    cmd       = '0;
    in_tready = 1'b0;
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    unique case (state_r)
      S_IDLE: begin
        in_tready  = 1'b1;
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_RO;
        if (in_tvalid) begin
          cmd.load  = 1'b1;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        cmd.capture_b = 1'b1;
        cmd.rd_en     = 1'b1;
        cmd.rd_sel    = RD_ZERO;
        if (stat.kind == KIND_READ || stat.kind == KIND_APPEND) begin
          cmd.mod_load = 1'b1;
          cnt_nxt      = SHW'(MOD_STEPS - 1);
          state_nxt    = S_MOD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_MOD: begin
        cmd.mod_step  = 1'b1;
        cmd.mod_shift = cnt_r;
        if (cnt_r == '0) begin
          state_nxt = (stat.kind == KIND_READ) ? S_RDM : S_FIN;
        end else begin
          cnt_nxt = cnt_r - SHW'(1);
        end
      end
      S_RDM: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_REM;
        state_nxt  = S_FIN;
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.commit = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Result beat holds until taken
  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

  // A result only appears from the final step of an operation.
  a_rise_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_FIN)
    else $error("result raised outside final step");

  // Only append and read run the remainder unit.
  a_mod_kind: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_MOD |-> (stat.kind == KIND_READ || stat.kind == KIND_APPEND))
    else $error("remainder unit used by wrong kind");

  // The remainder unit takes exactly its step count before leaving.
  a_mod_len: assert property (@(posedge clk) disable iff (!rst_n)
    $past(state_r) == S_LOOK && state_r == S_MOD |-> cnt_r == SHW'(MOD_STEPS - 1))
    else $error("remainder count not loaded");

endmodule

/* src/vlmr_dpath.sv */
module vlmr_dpath (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [12:0]          cfg_wr_data,
  input  logic [2:0]           in_kind,
  input  logic [7:0]           in_request_length,
  input  logic [7:0]           in_data_byte,
  input  logic [7:0]           in_byte_index,
  input  vlmr_pkg::vlmr_cmd_t  cmd,
  output vlmr_pkg::vlmr_stat_t stat,
  output logic [2:0]           out_status,
  output logic [7:0]           out_message_length,
  output logic [7:0]           out_read_data,
  output logic [11:0]          out_payload_offset,
  output logic [12:0]          out_pending_events,
  output logic [31:0]          out_overflow_count
);
  import vlmr_pkg::*;

  // Ring memory with registered read
  logic [7:0]    mem [RING_BYTES];
  logic [7:0]    mem_q_raw;
  logic          rz_r;
  logic [7:0]    mem_q;
  logic [AW-1:0] rd_addr;
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [7:0]    mem_wdata;

  // Architectural state
  logic [LW-1:0] active_r, active_nxt, cfg_sat;
  logic [AW-1:0] ro_r, ro_nxt, wo_r, wo_nxt;
  logic [7:0]    seg_req_r, seg_req_nxt, room_r, room_nxt;
  logic [31:0]   sent_r, sent_nxt, ack_r, ack_nxt, ovf_r, ovf_nxt;
  logic          zero0_r;

  // Operation scratch
  logic [2:0]    kind_r;
  logic [7:0]    req_r, dbyte_r, idx_r, b_r;
  logic [LW-1:0] rem_r, rem_nxt;
  logic [20:0]   mod_sub;

  // Commit results
  logic [2:0]    sts;
  logic [7:0]    mlen, rdata;
  logic [AW-1:0] poff;
  logic [LW-1:0] pend;
  logic [31:0]   diff;
  logic [LW-1:0] wo_inc, ro_inc, need, avail, nextp;
  logic [AW-1:0] wo1, ro1;
  logic [7:0]    used;
  logic          full, wrapped;

  assign stat.kind = kind_r;

  // Ring read address and read port; byte 0 reads as zero until written
  always_comb begin
    unique case (cmd.rd_sel)
      RD_RO:   rd_addr = ro_r;
      RD_ZERO: rd_addr = '0;
      RD_REM:  rd_addr = rem_r[AW-1:0];
      default: rd_addr = ro_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (cmd.rd_en) begin
      mem_q_raw <= mem[rd_addr];
      rz_r      <= (rd_addr == '0) && zero0_r;
    end
  end

  assign mem_q = rz_r ? 8'd0 : mem_q_raw;

  // Offsets one past the length byte, wrapped at active_length
  assign used   = seg_req_r - room_r;
  assign wo_inc = {1'b0, wo_r} + LW'(1);
  assign ro_inc = {1'b0, ro_r} + LW'(1);
  assign wo1    = (wo_inc == active_r) ? '0 : wo_inc[AW-1:0];
  assign ro1    = (ro_inc == active_r) ? '0 : ro_inc[AW-1:0];

  // Restoring remainder by active_length, one shifted subtract per step
  assign mod_sub = 21'(active_r) << cmd.mod_shift;
  always_comb begin
    rem_nxt = rem_r;
    if (cmd.mod_load) begin
      if (kind_r == KIND_READ) begin
        rem_nxt = ro_inc + LW'(idx_r);
      end else begin
        rem_nxt = wo_inc + LW'(used);
      end
    end else if (cmd.mod_step) begin
      if (21'(rem_r) >= mod_sub) begin
        rem_nxt = rem_r - mod_sub[LW-1:0];
      end
    end
  end

  // Saturated configuration value
  always_comb begin
    if (cfg_wr_data < LW'(MIN_ACTIVE)) begin
      cfg_sat = LW'(MIN_ACTIVE);
    end else if (cfg_wr_data > LW'(RING_BYTES)) begin
      cfg_sat = LW'(RING_BYTES);
    end else begin
      cfg_sat = cfg_wr_data;
    end
  end

  // Final step of each operation
  always_comb begin
    active_nxt  = active_r;
    ro_nxt      = ro_r;
    wo_nxt      = wo_r;
    seg_req_nxt = seg_req_r;
    room_nxt    = room_r;
    sent_nxt    = sent_r;
    ack_nxt     = ack_r;
    ovf_nxt     = ovf_r;
    sts         = STS_OK;
    mlen        = '0;
    rdata       = '0;
    poff        = '0;
    mem_we      = 1'b0;
    mem_waddr   = wo_r;
    mem_wdata   = '0;
    need        = LW'(in_request_length) + LW'(1);
    avail       = '0;
    nextp       = '0;
    full        = 1'b0;
    wrapped     = 1'b0;
    unique case (kind_r)
      KIND_ALLOC: begin
        need = LW'(req_r) + LW'(1);
        if (req_r > 8'(MAX_PAYLOAD)) begin
          sts = STS_TOO_LONG;
        end else begin
          if (wo_r >= ro_r) begin
            if (wo_r == ro_r && ack_r != sent_r) begin
              full = 1'b1;
            end else begin
              avail = active_r - {1'b0, wo_r};
              if (avail < need) begin
                // Not enough room at the tail: mark the wrap and restart at 0
                mem_we    = 1'b1;
                mem_waddr = wo_r;
                mem_wdata = WRAP_MARK;
                wo_nxt    = '0;
                wrapped   = 1'b1;
                avail     = {1'b0, ro_r};
              end
            end
          end else begin
            avail = {1'b0, ro_r} - {1'b0, wo_r};
          end
          if (!full && avail >= need) begin
            seg_req_nxt = req_r;
            room_nxt    = req_r;
            poff        = wrapped ? AW'(1) : wo1;
          end else begin
            ovf_nxt = ovf_r + 32'd1;
            sts     = STS_OVERFLOW;
          end
        end
      end
      KIND_APPEND: begin
        poff = wo1;
        if (room_r == '0) begin
          sts = STS_OUTSIDE;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = rem_r[AW-1:0];
          mem_wdata = dbyte_r;
          room_nxt  = room_r - 8'd1;
        end
      end
      KIND_POST: begin
        mem_we    = 1'b1;
        mem_waddr = wo_r;
        mem_wdata = used;
        mlen      = used;
        poff      = wo1;
        nextp     = wo_inc + LW'(used);
        wo_nxt    = (nextp >= active_r) ? '0 : nextp[AW-1:0];
        room_nxt  = '0;
        sent_nxt  = sent_r + 32'd1;
      end
      KIND_OPEN: begin
        if (sent_r == ack_r) begin
          sts = STS_EMPTY;
        end else begin
          ack_nxt = ack_r + 32'd1;
          if (b_r == '0) begin
            sts = STS_EMPTY;
          end else if (b_r == WRAP_MARK) begin
            ro_nxt = '0;
            mlen   = mem_q;
            poff   = AW'(1);
          end else begin
            mlen = b_r;
            poff = ro1;
          end
        end
      end
      KIND_READ: begin
        poff = ro1;
        if (b_r == WRAP_MARK || idx_r >= b_r) begin
          sts = STS_OUTSIDE;
        end else begin
          mlen  = b_r;
          rdata = mem_q;
        end
      end
      KIND_FREE: begin
        mlen   = b_r;
        poff   = ro1;
        nextp  = ro_inc + LW'(b_r);
        ro_nxt = (nextp >= active_r) ? '0 : nextp[AW-1:0];
      end
      default: begin
      end
    endcase
    if (!cmd.commit) begin
      mem_we = 1'b0;
    end
  end

  assign diff = sent_nxt - ack_nxt;
  assign pend = (diff > 32'(RING_BYTES)) ? LW'(RING_BYTES) : diff[LW-1:0];

  // Control state: reset and configuration re-initialize the ring
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= LW'(RING_BYTES);
      ro_r      <= '0;
      wo_r      <= '0;
      seg_req_r <= '0;
      room_r    <= '0;
      sent_r    <= '0;
      ack_r     <= '0;
      ovf_r     <= '0;
      zero0_r   <= 1'b1;
    end else if (cfg_wr_en) begin
      active_r  <= cfg_sat;
      ro_r      <= '0;
      wo_r      <= '0;
      seg_req_r <= '0;
      room_r    <= '0;
      sent_r    <= '0;
      ack_r     <= '0;
      ovf_r     <= '0;
      zero0_r   <= 1'b1;
    end else if (cmd.commit) begin
      active_r  <= active_nxt;
      ro_r      <= ro_nxt;
      wo_r      <= wo_nxt;
      seg_req_r <= seg_req_nxt;
      room_r    <= room_nxt;
      sent_r    <= sent_nxt;
      ack_r     <= ack_nxt;
      ovf_r     <= ovf_nxt;
      if (mem_we && mem_waddr == '0) begin
        zero0_r <= 1'b0;
      end
    end
  end

  // Operation operands, scratch and result beat
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r  <= in_kind;
      req_r   <= in_request_length;
      dbyte_r <= in_data_byte;
      idx_r   <= in_byte_index;
    end
    if (cmd.capture_b) begin
      b_r <= mem_q;
    end
    rem_r <= rem_nxt;
    if (cmd.commit) begin
      out_status         <= sts;
      out_message_length <= mlen;
      out_read_data      <= rdata;
      out_payload_offset <= poff;
      out_pending_events <= pend;
      out_overflow_count <= ovf_nxt;
    end
  end

  // Both offsets always lie inside the active part of the ring.
  a_offsets: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, wo_r} < active_r && {1'b0, ro_r} < active_r)
    else $error("ring offset beyond active length");

  // The acknowledge count moves only when an open commits.
  a_ack_open: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && !$past(cfg_wr_en) && ack_r != $past(ack_r)
    |-> $past(cmd.commit) && $past(kind_r) == KIND_OPEN)
    else $error("acknowledge count moved outside open");

  // An append writes at an address already reduced into the ring.
  a_append_addr: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && kind_r == KIND_APPEND |-> rem_r < active_r)
    else $error("append address not reduced");

endmodule

/* src/variable_length_message_ring_top.sv */
// Variable-length message ring.
// Input channel in_*: one beat carries one operation (allocate, append byte,
// post, open oldest, read byte, free). Result channel out_*: exactly one
// result beat per operation, in order. cfg_wr_en with cfg_wr_data sets the
// active ring length (saturated to 16..4096) and re-initializes offsets,
// segment state and counters; write it only while no operation is in flight.
// Allocate, post, open and free pass from the input beat through a lookup
// step to the final step; append and read byte also run a 9-step shared
// remainder unit that reduces the payload address by the active length,
// and read byte then reads the ring at that address. One operation is in
// work at a time; the ring memory's read port is registered, hence the lookup step.
// A new input beat is taken while the previous result still waits; a
// stalled receiver holds the result beat stable and parks the next
// operation at its final step until the result is taken.
// Reset sets the active length to 4096 and clears all pointers and
// counters. There is no clearing pass: only ring byte 0 is tracked as zero.
module variable_length_message_ring_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [12:0] cfg_wr_data,
  input  logic        in_tvalid,
  output logic        in_tready,
  // kind[2:0], request_length[10:3], data_byte[18:11], byte_index[26:19]
  input  logic [31:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // status[2:0], message_length[10:3], read_data[18:11], payload_offset[30:19],
  // pending_events[43:31], overflow_count[75:44]
  output logic [79:0] out_tdata
);
  import vlmr_pkg::*;

  vlmr_cmd_t   cmd;
  vlmr_stat_t  stat;
  logic [2:0]  status;
  logic [7:0]  message_length;
  logic [7:0]  read_data;
  logic [11:0] payload_offset;
  logic [12:0] pending_events;
  logic [31:0] overflow_count;

  vlmr_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .stat       (stat),
    .cmd        (cmd)
  );

  vlmr_dpath u_dpath (
    .clk                (clk),
    .rst_n              (rst_n),
    .cfg_wr_en          (cfg_wr_en),
    .cfg_wr_data        (cfg_wr_data),
    .in_kind            (in_tdata[2:0]),
    .in_request_length  (in_tdata[10:3]),
    .in_data_byte       (in_tdata[18:11]),
    .in_byte_index      (in_tdata[26:19]),
    .cmd                (cmd),
    .stat               (stat),
    .out_status         (status),
    .out_message_length (message_length),
    .out_read_data      (read_data),
    .out_payload_offset (payload_offset),
    .out_pending_events (pending_events),
    .out_overflow_count (overflow_count)
  );

  // Result beat packing
  assign out_tdata = {4'd0, overflow_count, pending_events, payload_offset,
                      read_data, message_length, status};

endmodule
